FILE: rtl/core/cdpc_pkg.sv
// Shared types, widths and codes for the charge-division position calibrator.
// No dependencies; the interfaces and the top level import this package.
package cdpc_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int GROUP_W    = 6;
  localparam int UNIT_W     = 4;
  localparam int CIDX_W     = 2;
  localparam int POS_W      = 17;
  localparam int COEF_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CLAMP_W    = 2;
  localparam int COUNT_W    = 32;
  localparam int GCOUNT_W   = 7;
  localparam int GSIZE_W    = 5;

  // Default table dimensions
  localparam int CDPC_MAX_GROUPS = 64;
  localparam int CDPC_MAX_UNITS  = 16;
  localparam int COEFF_COUNT     = 4;

  // Horner datapath: running term, product of position and term, 16-bit fraction shift, one in Q24
  localparam int FRAC_W = 16;
  localparam int T_W    = 36;
  localparam int PROD_W = POS_W + 1 + T_W;
  localparam int ADD_W  = PROD_W - FRAC_W;
  localparam logic [ADD_W-1:0] ONE_Q24 = ADD_W'(1) << 24;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_GROUP_COUNT = 1'b0;
  localparam logic REG_GROUP_SIZE  = 1'b1;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_WR_IVL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_COEF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVENT   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GRP_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  // Clamp codes
  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

  // Coefficient positions in a unit's row
  localparam logic [CIDX_W-1:0] COEF_D = 2'd3;
  localparam logic [CIDX_W-1:0] COEF_C = 2'd2;

endpackage

FILE: rtl/core/cdpc_in_if.sv
// Request channel of the calibrator: valid/ready handshake and request payload.
// Depends on cdpc_pkg for field widths.
interface cdpc_in_if import cdpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [GROUP_W-1:0]       group;
  logic [UNIT_W-1:0]        unit;
  logic [CIDX_W-1:0]        coeff_index;
  logic [POS_W-1:0]         interval_low;
  logic [POS_W-1:0]         interval_high;
  logic signed [COEF_W-1:0] coeff_value;
  logic [POS_W-1:0]         global_pos;
  logic [POS_W-1:0]         pos_in;

  modport source (
    output valid, cmd, group, unit, coeff_index, interval_low, interval_high,
           coeff_value, global_pos, pos_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, group, unit, coeff_index, interval_low, interval_high,
           coeff_value, global_pos, pos_in,
    output ready
  );
endinterface

FILE: rtl/core/cdpc_out_if.sv
// Result channel of the calibrator: valid/ready handshake and result payload.
// Depends on cdpc_pkg for field widths.
interface cdpc_out_if import cdpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CLAMP_W-1:0]   clamp;
  logic [UNIT_W-1:0]    unit_found;
  logic [POS_W-1:0]     corrected_pos;
  logic [COUNT_W-1:0]   clamp_low_count;
  logic [COUNT_W-1:0]   clamp_high_count;
  logic [COUNT_W-1:0]   group_error_count;
  logic [COUNT_W-1:0]   outside_count;

  modport source (
    output valid, status, clamp, unit_found, corrected_pos, clamp_low_count,
           clamp_high_count, group_error_count, outside_count,
    input  ready
  );
  modport sink (
    input  valid, status, clamp, unit_found, corrected_pos, clamp_low_count,
           clamp_high_count, group_error_count, outside_count,
    output ready
  );
endinterface

FILE: rtl/core/cdpc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module cdpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/charge_division_position_calibrator_unit.sv
// Charge-division position calibrator: top level with sequencer and Horner datapath.
// Depends on cdpc_pkg, cdpc_in_if, cdpc_out_if and cdpc_ram.
//
// Usage
//   in_req  : request channel (valid/ready). A request either writes an interval
//             or a cubic coefficient into the per-group, per-unit tables, or
//             carries an event to be corrected.
//   out_res : one result per request, with status, clamp flag, unit found, the
//             corrected Q1.16 position and the four wrapping event counters.
//   cfg_*   : APB-style port; group_count at 0x0, group_size at 0x4.
//   A request is taken only while the sequencer is idle. Table writes and
//   group errors go from the decode state straight to the emit state. An event scans
//   the group's intervals one per cycle through the interval RAM read port,
//   then runs three multiply/add passes over one shared 18x36 multiplier and
//   clamps the result; an event outside every interval goes to the emit state
//   once every unit of its group has been scanned.
//   The result sits in an output register; the next request is accepted while
//   it waits. If the receiver stalls, a finished result waits in the sequencer
//   until the output register frees.
//   Reset clears the counters, the configuration registers and the handshake
//   state. The tables are not cleared and must be written before use.
module charge_division_position_calibrator_unit
  import cdpc_pkg::*;
#(
  parameter int MAX_GROUPS = CDPC_MAX_GROUPS,
  parameter int MAX_UNITS  = CDPC_MAX_UNITS
) (
  input  logic              clk,
  input  logic              rst_n,
  cdpc_in_if.sink           in_req,
  cdpc_out_if.source        out_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IVL_DEPTH  = MAX_GROUPS * MAX_UNITS;
  localparam int IVL_AW     = (IVL_DEPTH > 1) ? $clog2(IVL_DEPTH) : 1;
  localparam int IVL_W      = 2 * POS_W;
  localparam int COEF_DEPTH = IVL_DEPTH * COEFF_COUNT;
  localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SRCH   = 3'd2;
  localparam logic [2:0] S_CINIT  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Captured request
  logic [CMD_W-1:0]         cmd_r;
  logic [GROUP_W-1:0]       grp_r;
  logic [UNIT_W-1:0]        unit_r;
  logic [CIDX_W-1:0]        ci_r;
  logic [POS_W-1:0]         ilo_r;
  logic [POS_W-1:0]         ihi_r;
  logic signed [COEF_W-1:0] cval_r;
  logic [POS_W-1:0]         gpos_r;
  logic [POS_W-1:0]         pos_r;

  // Configuration
  logic [GCOUNT_W-1:0] group_count_r;
  logic [GSIZE_W-1:0]  group_size_r;

  // Search and Horner state
  logic [GSIZE_W-1:0]       rd_u_r, rd_u_nxt;
  logic [GSIZE_W-1:0]       cmp_u_r, cmp_u_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [GSIZE_W-1:0]       found_u_r, found_u_nxt;
  logic [1:0]               step_r, step_nxt;
  logic signed [T_W-1:0]    t_r, t_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [COEF_W-1:0] coef_r;

  // Result waiting for the output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CLAMP_W-1:0]  res_clamp_r, res_clamp_nxt;
  logic [UNIT_W-1:0]   res_unit_r, res_unit_nxt;
  logic [POS_W-1:0]    res_corr_r, res_corr_nxt;

  // Counters
  logic [COUNT_W-1:0] clamp_low_total_r, clamp_low_total_nxt;
  logic [COUNT_W-1:0] clamp_high_total_r, clamp_high_total_nxt;
  logic [COUNT_W-1:0] group_error_total_r, group_error_total_nxt;
  logic [COUNT_W-1:0] outside_total_r, outside_total_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic [STATUS_W-1:0] out_status_r;
  logic [CLAMP_W-1:0]  out_clamp_r;
  logic [UNIT_W-1:0]   out_unit_r;
  logic [POS_W-1:0]    out_corr_r;
  logic [COUNT_W-1:0]  out_low_r, out_high_r, out_err_r, out_outside_r;

  // RAM ports
  logic               ivl_we, coef_we;
  logic [IVL_AW-1:0]  ivl_waddr, ivl_raddr;
  logic [IVL_W-1:0]   ivl_rdata;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [COEF_W-1:0]  coef_rdata;
  logic [GSIZE_W-1:0] coef_rd_unit;
  logic [CIDX_W-1:0]  coef_rd_idx;

  logic [31:0]        row_base;
  logic               in_take;
  logic               wr_in_range;
  logic               grp_bad;
  logic [GSIZE_W-1:0] n_units;
  logic [POS_W-1:0]   ivl_a, ivl_b;
  logic               ivl_hit;
  logic signed [ADD_W-1:0] c24;
  logic               cfg_wr;

  assign in_take      = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[CFG_AW-1])
      REG_GROUP_COUNT: cfg_prdata = CFG_DW'(group_count_r);
      REG_GROUP_SIZE:  cfg_prdata = CFG_DW'(group_size_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= '0;
      group_size_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[CFG_AW-1] == REG_GROUP_COUNT) begin
        group_count_r <= cfg_pwdata[GCOUNT_W-1:0];
      end else begin
        group_size_r <= cfg_pwdata[GSIZE_W-1:0];
      end
    end
  end

  // Table addressing
  assign row_base    = 32'(grp_r) * MAX_UNITS;
  assign wr_in_range = (32'(grp_r) < MAX_GROUPS) && (32'(unit_r) < MAX_UNITS);
  assign grp_bad     = ({1'b0, grp_r} >= group_count_r) || (32'(grp_r) >= MAX_GROUPS);
  assign n_units     = (32'(group_size_r) < MAX_UNITS) ? group_size_r : GSIZE_W'(MAX_UNITS);

  assign ivl_we     = (state_r == S_DECODE) && (cmd_r == CMD_WR_IVL) && wr_in_range;
  assign coef_we    = (state_r == S_DECODE) && (cmd_r == CMD_WR_COEF) && wr_in_range;
  assign ivl_waddr  = IVL_AW'(row_base + 32'(unit_r));
  assign ivl_raddr  = IVL_AW'(row_base + 32'(rd_u_r));
  assign coef_waddr = COEF_AW'((row_base + 32'(unit_r)) * COEFF_COUNT + 32'(ci_r));
  assign coef_raddr = COEF_AW'((row_base + 32'(coef_rd_unit)) * COEFF_COUNT
                               + 32'(coef_rd_idx));

  // Pick the coefficient to fetch: d on a hit, c at start, then one lower per pass
  always_comb begin
    case (state_r)
      S_SRCH: begin
        coef_rd_unit = cmp_u_r;
        coef_rd_idx  = COEF_D;
      end
      S_CINIT: begin
        coef_rd_unit = found_u_r;
        coef_rd_idx  = COEF_C;
      end
      default: begin
        coef_rd_unit = found_u_r;
        coef_rd_idx  = step_r - 2'd1;
      end
    endcase
  end

  cdpc_ram #(.WIDTH(IVL_W), .DEPTH(IVL_DEPTH)) u_ivl_ram (
    .clk   (clk),
    .we    (ivl_we),
    .waddr (ivl_waddr),
    .wdata ({ihi_r, ilo_r}),
    .raddr (ivl_raddr),
    .rdata (ivl_rdata)
  );

  cdpc_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (cval_r),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // Interval test, ends in either order
  assign ivl_a   = ivl_rdata[POS_W-1:0];
  assign ivl_b   = ivl_rdata[IVL_W-1:POS_W];
  assign ivl_hit = ((gpos_r >= ivl_a) && (gpos_r <= ivl_b))
                || ((gpos_r >= ivl_b) && (gpos_r <= ivl_a));

  // Corrected value in Q24
  assign c24 = $signed(ADD_W'({pos_r, 8'd0})) - ADD_W'(t_r);

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_res.ready);

  // Sequencer
  always_comb begin
    state_nxt             = state_r;
    rd_u_nxt              = rd_u_r;
    cmp_u_nxt             = cmp_u_r;
    cmp_vld_nxt           = cmp_vld_r;
    found_u_nxt           = found_u_r;
    step_nxt              = step_r;
    t_nxt                 = t_r;
    res_status_nxt        = res_status_r;
    res_clamp_nxt         = res_clamp_r;
    res_unit_nxt          = res_unit_r;
    res_corr_nxt          = res_corr_r;
    clamp_low_total_nxt   = clamp_low_total_r;
    clamp_high_total_nxt  = clamp_high_total_r;
    group_error_total_nxt = group_error_total_r;
    outside_total_nxt     = outside_total_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DECODE;
        end
      end

      // Writes and unused commands are acknowledged; events are checked
      S_DECODE: begin
        res_status_nxt = ST_OK;
        res_clamp_nxt  = CLAMP_NONE;
        res_unit_nxt   = '0;
        res_corr_nxt   = '0;
        state_nxt      = S_EMIT;
        if (cmd_r == CMD_EVENT) begin
          if (grp_bad) begin
            res_status_nxt        = ST_GRP_ERR;
            group_error_total_nxt = group_error_total_r + 1'b1;
          end else begin
            rd_u_nxt    = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_SRCH;
          end
        end
      end

      // Issue one interval read per cycle and test the previous one
      S_SRCH: begin
        if (cmp_vld_r && ivl_hit) begin
          found_u_nxt = cmp_u_r;
          state_nxt   = S_CINIT;
        end else if (rd_u_r < n_units) begin
          cmp_u_nxt   = rd_u_r;
          cmp_vld_nxt = 1'b1;
          rd_u_nxt    = rd_u_r + 1'b1;
        end else if (!cmp_vld_r) begin
          res_status_nxt    = ST_OUTSIDE;
          outside_total_nxt = outside_total_r + 1'b1;
          state_nxt         = S_EMIT;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      // Load d as the running term
      S_CINIT: begin
        t_nxt     = T_W'($signed(coef_rdata));
        step_nxt  = COEF_C;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        state_nxt = S_ADD;
      end

      // Add the next coefficient to floor(p * t / 2^16)
      S_ADD: begin
        t_nxt = T_W'(ADD_W'(coef_r) + $signed(prod_r[PROD_W-1:FRAC_W]));
        if (step_r == 2'd0) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r - 2'd1;
          state_nxt = S_MUL;
        end
      end

      // Subtract, clamp to [0,1] and count clamps
      S_FIN: begin
        res_unit_nxt = found_u_r[UNIT_W-1:0];
        state_nxt    = S_EMIT;
        if (c24[ADD_W-1]) begin
          res_clamp_nxt       = CLAMP_LOW;
          res_corr_nxt        = '0;
          clamp_low_total_nxt = clamp_low_total_r + 1'b1;
        end else if (c24 > $signed(ONE_Q24)) begin
          res_clamp_nxt        = CLAMP_HIGH;
          res_corr_nxt         = POS_W'(1) << FRAC_W;
          clamp_high_total_nxt = clamp_high_total_r + 1'b1;
        end else begin
          res_corr_nxt = c24[24:8];
        end
      end

      // Hold the result until the output register frees
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      rd_u_r              <= '0;
      cmp_vld_r           <= 1'b0;
      step_r              <= '0;
      out_valid_r         <= 1'b0;
      clamp_low_total_r   <= '0;
      clamp_high_total_r  <= '0;
      group_error_total_r <= '0;
      outside_total_r     <= '0;
    end else begin
      state_r             <= state_nxt;
      rd_u_r              <= rd_u_nxt;
      cmp_vld_r           <= cmp_vld_nxt;
      step_r              <= step_nxt;
      out_valid_r         <= out_valid_nxt;
      clamp_low_total_r   <= clamp_low_total_nxt;
      clamp_high_total_r  <= clamp_high_total_nxt;
      group_error_total_r <= group_error_total_nxt;
      outside_total_r     <= outside_total_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_req.cmd;
      grp_r  <= in_req.group;
      unit_r <= in_req.unit;
      ci_r   <= in_req.coeff_index;
      ilo_r  <= in_req.interval_low;
      ihi_r  <= in_req.interval_high;
      cval_r <= in_req.coeff_value;
      gpos_r <= in_req.global_pos;
      pos_r  <= in_req.pos_in;
    end
    cmp_u_r      <= cmp_u_nxt;
    found_u_r    <= found_u_nxt;
    t_r          <= t_nxt;
    prod_r       <= $signed({1'b0, pos_r}) * t_r;
    coef_r       <= coef_rdata;
    res_status_r <= res_status_nxt;
    res_clamp_r  <= res_clamp_nxt;
    res_unit_r   <= res_unit_nxt;
    res_corr_r   <= res_corr_nxt;
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_clamp_r   <= res_clamp_r;
      out_unit_r    <= res_unit_r;
      out_corr_r    <= res_corr_r;
      out_low_r     <= clamp_low_total_r;
      out_high_r    <= clamp_high_total_r;
      out_err_r     <= group_error_total_r;
      out_outside_r <= outside_total_r;
    end
  end

  // Result channel
  assign out_res.valid             = out_valid_r;
  assign out_res.status            = out_status_r;
  assign out_res.clamp             = out_clamp_r;
  assign out_res.unit_found        = out_unit_r;
  assign out_res.corrected_pos     = out_corr_r;
  assign out_res.clamp_low_count   = out_low_r;
  assign out_res.clamp_high_count  = out_high_r;
  assign out_res.group_error_count = out_err_r;
  assign out_res.outside_count     = out_outside_r;

endmodule
